// ----- rtl/hbt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbt_pkg
// Shared types and codes for the Huffman tree loader and decoder.
// ----------------------------------------------------------------------------
package hbt_pkg;

	localparam int MAX_NODES_DEF   = 511;
	localparam int STACK_DEPTH_DEF = 256;
	localparam int SYM_W           = 8;

	typedef logic [1:0] req_t;
	typedef logic [1:0] kind_t;

	// request types
	localparam req_t REQ_FLAG   = 2'd0;
	localparam req_t REQ_SYMBOL = 2'd1;
	localparam req_t REQ_CODE   = 2'd2;
	localparam req_t REQ_CLEAR  = 2'd3;

	// result kinds
	localparam kind_t KIND_SYMBOL   = 2'd0;
	localparam kind_t KIND_DONE     = 2'd1;
	localparam kind_t KIND_SEQ_ERR  = 2'd2;
	localparam kind_t KIND_OVERFLOW = 2'd3;

endpackage

// ----- rtl/huffman_tree_load_and_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode
// Loads a Huffman tree from its preorder description, then decodes code bits.
// ----------------------------------------------------------------------------
// Each input beat has its memory accesses issued as it is accepted, and the
// second stage finishes it with the node store or stack read data (right-child
// link of a finished leaf, or the next node of the walk), so in_stall is high
// from each accepted beat until its second stage completes. A code bit has to
// see the node it steers to before the next bit can be steered, so a new beat
// is not taken before the last one is through. Results go out through a
// registered output stage, so a stalled result holds the block for at most as
// long as the stall lasts. The tree is kept as a node store (leaf flag plus
// symbol or right-child index, in preorder) and a stack of internal nodes that
// still await their right child; neither memory is cleared after reset.
module huffman_tree_load_and_decode #(
	parameter int MAX_NODES   = hbt_pkg::MAX_NODES_DEF,
	parameter int STACK_DEPTH = hbt_pkg::STACK_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  hbt_pkg::req_t             req_type,
	input  logic                      bit_value,
	input  logic [hbt_pkg::SYM_W-1:0] symbol_in,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [hbt_pkg::SYM_W-1:0] symbol_out,
	output hbt_pkg::kind_t            result_kind
);

	localparam int IW = $clog2(MAX_NODES);
	localparam int NW = $clog2(MAX_NODES + 1);
	localparam int SW = $clog2(STACK_DEPTH);
	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam int PW = (NW > hbt_pkg::SYM_W) ? NW : hbt_pkg::SYM_W;
	localparam int EW = PW + 1;

	// control state
	logic [NW-1:0] nodes_used_q;
	logic [LW-1:0] stack_level_q;
	logic          awaiting_q;
	logic          tree_ready_q;
	logic [NW-1:0] walk_q;
	logic [EW-1:0] cur_q;
	logic [EW-1:0] root_q;

	// second stage
	logic                      valid_s2;
	logic                      res_s2;
	hbt_pkg::kind_t            kind_s2;
	logic [hbt_pkg::SYM_W-1:0] sym_s2;
	logic                      pop_s2;
	logic                      walk_s2;
	logic                      home_s2;
	logic [NW-1:0]             next_s2;
	logic [NW-1:0]             link_s2;

	// output register
	logic                      out_valid_q;
	logic [hbt_pkg::SYM_W-1:0] symbol_out_q;
	hbt_pkg::kind_t            result_kind_q;

	// memory ports
	logic          nwr_en;
	logic [IW-1:0] nwr_addr;
	logic [EW-1:0] nwr_data;
	logic          nrd_en;
	logic [IW-1:0] nrd_addr;
	logic [EW-1:0] nrd_data;
	logic          swr_en;
	logic [SW-1:0] swr_addr;
	logic [IW-1:0] swr_data;
	logic          srd_en;
	logic [SW-1:0] srd_addr;
	logic [IW-1:0] srd_data;

	// first stage decisions
	logic                      acc;
	logic                      s1_wr_en;
	logic [IW-1:0]             s1_wr_addr;
	logic [EW-1:0]             s1_wr_data;
	logic [NW-1:0]             nodes_used_d;
	logic [LW-1:0]             stack_level_d;
	logic                      awaiting_d;
	logic                      tree_ready_d;
	logic                      res_d;
	hbt_pkg::kind_t            kind_d;
	logic [hbt_pkg::SYM_W-1:0] sym_d;
	logic                      pop_d;
	logic                      walk_d;
	logic                      home_d;
	logic                      clear_walk_d;
	logic [NW-1:0]             next_d;
	logic [NW-1:0]             next_pos;
	logic [LW-1:0]             level_dec;
	logic [NW-1:0]             nodes_dec;

	// second stage completion
	logic rd_leaf;
	logic has_res;
	logic s2_fire;
	logic out_free;

	assign acc       = in_valid && !in_stall;
	assign in_stall  = valid_s2;
	assign level_dec = stack_level_q - LW'(1);
	assign nodes_dec = nodes_used_q - NW'(1);
	assign next_pos  = bit_value ? (walk_q + NW'(1)) : cur_q[NW-1:0];

	always_comb begin
		s1_wr_en      = 1'b0;
		s1_wr_addr    = nodes_used_q[IW-1:0];
		s1_wr_data    = '0;
		swr_en        = 1'b0;
		swr_addr      = stack_level_q[SW-1:0];
		swr_data      = nodes_used_q[IW-1:0];
		srd_en        = 1'b0;
		srd_addr      = level_dec[SW-1:0];
		nrd_en        = 1'b0;
		nrd_addr      = next_pos[IW-1:0];
		nodes_used_d  = nodes_used_q;
		stack_level_d = stack_level_q;
		awaiting_d    = awaiting_q;
		tree_ready_d  = tree_ready_q;
		res_d         = 1'b0;
		kind_d        = hbt_pkg::KIND_SEQ_ERR;
		sym_d         = '0;
		pop_d         = 1'b0;
		walk_d        = 1'b0;
		home_d        = 1'b0;
		clear_walk_d  = 1'b0;
		next_d        = next_pos;
		case (req_type)
			hbt_pkg::REQ_FLAG: begin
				if (awaiting_q || tree_ready_q) begin
					res_d = 1'b1;
				end else if (nodes_used_q >= NW'(MAX_NODES) ||
						(!bit_value && stack_level_q >= LW'(STACK_DEPTH))) begin
					res_d         = 1'b1;
					kind_d        = hbt_pkg::KIND_OVERFLOW;
					nodes_used_d  = '0;
					stack_level_d = '0;
					awaiting_d    = 1'b0;
				end else begin
					s1_wr_en     = acc;
					s1_wr_data   = {bit_value, PW'(0)};
					nodes_used_d = nodes_used_q + NW'(1);
					if (bit_value) begin
						awaiting_d = 1'b1;
					end else begin
						swr_en        = acc;
						stack_level_d = stack_level_q + LW'(1);
					end
				end
			end
			hbt_pkg::REQ_SYMBOL: begin
				if (!awaiting_q) begin
					res_d = 1'b1;
				end else begin
					s1_wr_en   = acc;
					s1_wr_addr = nodes_dec[IW-1:0];
					s1_wr_data = {1'b1, PW'(symbol_in)};
					awaiting_d = 1'b0;
					if (stack_level_q == '0) begin
						res_d        = 1'b1;
						kind_d       = hbt_pkg::KIND_DONE;
						tree_ready_d = 1'b1;
						home_d       = 1'b1;
					end else begin
						// parent index comes back from the stack next cycle
						stack_level_d = level_dec;
						srd_en        = acc;
						pop_d         = 1'b1;
					end
				end
			end
			hbt_pkg::REQ_CODE: begin
				if (!tree_ready_q) begin
					res_d = 1'b1;
				end else if (cur_q[PW]) begin
					// one-leaf tree: the root itself is the leaf
					res_d  = 1'b1;
					kind_d = hbt_pkg::KIND_SYMBOL;
					sym_d  = cur_q[hbt_pkg::SYM_W-1:0];
					home_d = 1'b1;
				end else if (next_pos >= NW'(MAX_NODES)) begin
					home_d = 1'b1;
				end else begin
					nrd_en = acc;
					walk_d = 1'b1;
				end
			end
			default: begin
				nodes_used_d  = '0;
				stack_level_d = '0;
				awaiting_d    = 1'b0;
				tree_ready_d  = 1'b0;
				clear_walk_d  = 1'b1;
			end
		endcase
	end

	assign rd_leaf  = nrd_data[PW];
	assign has_res  = res_s2 || (walk_s2 && rd_leaf);
	assign out_free = !out_valid_q || !out_stall;
	assign s2_fire  = valid_s2 && (!has_res || out_free);

	// parent link write from the second stage never meets a first stage write
	always_comb begin
		if (valid_s2 && pop_s2) begin
			nwr_en   = s2_fire;
			nwr_addr = srd_data;
			nwr_data = {1'b0, PW'(link_s2)};
		end else begin
			nwr_en   = s1_wr_en;
			nwr_addr = s1_wr_addr;
			nwr_data = s1_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_used_q  <= '0;
			stack_level_q <= '0;
			awaiting_q    <= 1'b0;
			tree_ready_q  <= 1'b0;
			walk_q        <= '0;
			valid_s2      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (acc) begin
				nodes_used_q  <= nodes_used_d;
				stack_level_q <= stack_level_d;
				awaiting_q    <= awaiting_d;
				tree_ready_q  <= tree_ready_d;
				valid_s2      <= 1'b1;
				if (clear_walk_d) begin
					walk_q <= '0;
				end
			end else if (s2_fire) begin
				valid_s2 <= 1'b0;
				if (home_s2 || (walk_s2 && rd_leaf)) begin
					walk_q <= '0;
				end else if (walk_s2) begin
					walk_q <= next_s2;
				end
			end
			if (s2_fire && has_res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s2  <= res_d;
			kind_s2 <= kind_d;
			sym_s2  <= sym_d;
			pop_s2  <= pop_d;
			walk_s2 <= walk_d;
			home_s2 <= home_d;
			next_s2 <= next_d;
			link_s2 <= nodes_used_q;
		end
		if (nwr_en && nwr_addr == '0) begin
			root_q <= nwr_data;
		end
		if (s2_fire) begin
			if (home_s2 || (walk_s2 && rd_leaf)) begin
				cur_q <= root_q;
			end else if (walk_s2) begin
				cur_q <= nrd_data;
			end
		end
		if (s2_fire && has_res) begin
			if (walk_s2) begin
				symbol_out_q  <= nrd_data[hbt_pkg::SYM_W-1:0];
				result_kind_q <= hbt_pkg::KIND_SYMBOL;
			end else begin
				symbol_out_q  <= sym_s2;
				result_kind_q <= kind_s2;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign symbol_out  = symbol_out_q;
	assign result_kind = result_kind_q;

	hbt_ram #(
		.DEPTH (MAX_NODES),
		.WIDTH (EW)
	) u_node_store (
		.clk     (clk),
		.wr_en   (nwr_en),
		.wr_addr (nwr_addr),
		.wr_data (nwr_data),
		.rd_en   (nrd_en),
		.rd_addr (nrd_addr),
		.rd_data (nrd_data)
	);

	hbt_ram #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (IW)
	) u_right_stack (
		.clk     (clk),
		.wr_en   (swr_en),
		.wr_addr (swr_addr),
		.wr_data (swr_data),
		.rd_en   (srd_en),
		.rd_addr (srd_addr),
		.rd_data (srd_data)
	);

endmodule

// ----- rtl/hbt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbt_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module hbt_ram #(
	parameter int DEPTH = hbt_pkg::MAX_NODES_DEF,
	parameter int WIDTH = 9
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
